[hdl/source_code_tokenizer_assert.svh]
// Assertion macros used by the tokenizer result queue.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef SOURCE_CODE_TOKENIZER_ASSERT_SVH
`define SOURCE_CODE_TOKENIZER_ASSERT_SVH

// Same-cycle implication.
`define SCT_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SCT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/sct_pkg.sv]
// ----------------------------------------------------------------------------
// sct_pkg
// Types, token codes and character tables shared by the tokenizer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sct_pkg;

    localparam int KIND_W = 6;
    localparam int LINE_W = 32;
    localparam int COL_W  = 16;
    localparam int LEN_W  = 16;
    localparam int ERR_W  = 3;

    localparam logic [KIND_W-1:0] TK_EOF = 6'd0, TK_BOOL = 6'd1, TK_INT = 6'd2,
        TK_FLOAT = 6'd3, TK_STRING = 6'd4, TK_IDENT = 6'd5, TK_FUNC = 6'd6,
        TK_STRUCT = 6'd7, TK_IF = 6'd8, TK_ELIF = 6'd9, TK_ELSE = 6'd10,
        TK_WHILE = 6'd11, TK_FOR = 6'd12, TK_DO = 6'd13, TK_RETURN = 6'd14,
        TK_BREAK = 6'd15, TK_CONTINUE = 6'd16, TK_GOTO = 6'd17;
    localparam logic [KIND_W-1:0] TK_COLON = 6'd18, TK_SEMI = 6'd19, TK_COMMA = 6'd20,
        TK_LPAREN = 6'd21, TK_RPAREN = 6'd22, TK_LBRACE = 6'd23, TK_RBRACE = 6'd24,
        TK_LBRACK = 6'd25, TK_RBRACK = 6'd26, TK_ADD = 6'd27, TK_SUB = 6'd28,
        TK_MUL = 6'd29, TK_DIV = 6'd30, TK_MOD = 6'd31, TK_AND = 6'd32,
        TK_OR = 6'd33, TK_XOR = 6'd34, TK_LAND = 6'd35, TK_LOR = 6'd36,
        TK_LT = 6'd37, TK_LE = 6'd38, TK_GT = 6'd39, TK_GE = 6'd40, TK_EQ = 6'd41,
        TK_NE = 6'd42, TK_DOT = 6'd43, TK_QUEST = 6'd44, TK_TILDE = 6'd45,
        TK_NOT = 6'd46, TK_INC = 6'd47, TK_DEC = 6'd48, TK_ASSIGN = 6'd49,
        TK_ADD_EQ = 6'd50, TK_SUB_EQ = 6'd51, TK_MUL_EQ = 6'd52, TK_DIV_EQ = 6'd53,
        TK_MOD_EQ = 6'd54;

    localparam logic [ERR_W-1:0] ERR_NONE = 3'd0, ERR_EOF_COMMENT = 3'd1,
        ERR_STRAY_CLOSE = 3'd2, ERR_EOF_STRING = 3'd3, ERR_UNKNOWN = 3'd4;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [LINE_W-1:0] line;
        logic [COL_W-1:0]  column;
        logic [LEN_W-1:0]  length;
        logic [ERR_W-1:0]  err;
        logic              last;
    } res_t;

    // Results produced by one accepted byte.
    typedef struct packed {
        logic [1:0] count;
        res_t       r0;
        res_t       r1;
    } push_t;

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic [KIND_W-1:0] single_kind(input logic [7:0] b);
        logic [KIND_W-1:0] k;
        case (b)
            ":": k = TK_COLON;   ";": k = TK_SEMI;    ",": k = TK_COMMA;
            "(": k = TK_LPAREN;  ")": k = TK_RPAREN;  "{": k = TK_LBRACE;
            "}": k = TK_RBRACE;  "[": k = TK_LBRACK;  "]": k = TK_RBRACK;
            "+": k = TK_ADD;     "-": k = TK_SUB;     "*": k = TK_MUL;
            "/": k = TK_DIV;     "%": k = TK_MOD;     "&": k = TK_AND;
            "|": k = TK_OR;      "^": k = TK_XOR;     "<": k = TK_LT;
            ">": k = TK_GT;      ".": k = TK_DOT;     "?": k = TK_QUEST;
            "~": k = TK_TILDE;   "!": k = TK_NOT;     "=": k = TK_ASSIGN;
            default: k = TK_EOF;
        endcase
        return k;
    endfunction

    function automatic logic [KIND_W-1:0] pair_kind(input logic [7:0] p, input logic [7:0] b);
        logic [KIND_W-1:0] k;
        k = TK_EOF;
        if (b == "=") begin
            case (p)
                "+": k = TK_ADD_EQ; "-": k = TK_SUB_EQ; "*": k = TK_MUL_EQ;
                "/": k = TK_DIV_EQ; "%": k = TK_MOD_EQ; "<": k = TK_LE;
                ">": k = TK_GE;     "!": k = TK_NE;     "=": k = TK_EQ;
                default: k = TK_EOF;
            endcase
        end else if (p == "+" && b == "+") k = TK_INC;
        else if (p == "-" && b == "-") k = TK_DEC;
        else if (p == "&" && b == "&") k = TK_LAND;
        else if (p == "|" && b == "|") k = TK_LOR;
        return k;
    endfunction

    // Text is right-aligned in the word: the first character sits highest.
    function automatic logic kw_eq(input logic [7:0][7:0] p, input logic [3:0] len,
                                   input logic [63:0] txt, input logic [3:0] tl);
        logic same;
        same = (len == tl);
        for (int j = 0; j < 8; j++) begin
            if (j < int'(tl) && p[j] != txt[8*(int'(tl)-1-j) +: 8]) same = 1'b0;
        end
        return same;
    endfunction

    function automatic logic [KIND_W-1:0] kw_kind(input logic [7:0][7:0] p,
                                                  input logic [3:0] len);
        logic [KIND_W-1:0] k;
        k = TK_IDENT;
        if (kw_eq(p, len, 64'("do"), 4'd2))       k = TK_DO;
        if (kw_eq(p, len, 64'("for"), 4'd3))      k = TK_FOR;
        if (kw_eq(p, len, 64'("else"), 4'd4))     k = TK_ELSE;
        if (kw_eq(p, len, 64'("false"), 4'd5))    k = TK_BOOL;
        if (kw_eq(p, len, 64'("struct"), 4'd6))   k = TK_STRUCT;
        if (kw_eq(p, len, 64'("if"), 4'd2))       k = TK_IF;
        if (kw_eq(p, len, 64'("elif"), 4'd4))     k = TK_ELIF;
        if (kw_eq(p, len, 64'("while"), 4'd5))    k = TK_WHILE;
        if (kw_eq(p, len, 64'("return"), 4'd6))   k = TK_RETURN;
        if (kw_eq(p, len, 64'("true"), 4'd4))     k = TK_BOOL;
        if (kw_eq(p, len, 64'("break"), 4'd5))    k = TK_BREAK;
        if (kw_eq(p, len, 64'("func"), 4'd4))     k = TK_FUNC;
        if (kw_eq(p, len, 64'("continue"), 4'd8)) k = TK_CONTINUE;
        if (kw_eq(p, len, 64'("goto"), 4'd4))     k = TK_GOTO;
        return k;
    endfunction

endpackage

`default_nettype wire

[hdl/sct_front.sv]
// ----------------------------------------------------------------------------
// sct_front
// Scanner: takes one source byte per transfer and produces up to two results.
// ----------------------------------------------------------------------------
`default_nettype none

module sct_front #(
    parameter int KEYWORD_MAX_BYTES = 8,
    parameter int LINE_BITS         = 32,
    parameter int COLUMN_BITS       = 16,
    parameter int DEPTH_BITS        = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire logic [7:0]    source_byte,
    output sct_pkg::push_t     push
);
    import sct_pkg::*;

    localparam int IDXW = $clog2(KEYWORD_MAX_BYTES);
    localparam logic [LINE_BITS-1:0]   LINE_MAX  = '1;
    localparam logic [COLUMN_BITS-1:0] COL_MAX   = '1;
    localparam logic [DEPTH_BITS-1:0]  DEPTH_MAX = '1;
    localparam logic [LEN_W-1:0]       LEN_MAX   = '1;

    typedef enum logic [3:0] {
        M_IDLE, M_OP, M_IDENT, M_INT, M_FLT, M_STR, M_STR_ESC, M_LINE_C,
        M_BLOCK, M_BLOCK_SLASH, M_BLOCK_STAR, M_DRAIN
    } mode_t;

    typedef enum logic [1:0] {NL_NONE, NL_LF, NL_CR} nl_t;

    typedef struct packed {
        mode_t                  mode;
        logic [7:0]             pend;
        logic [LINE_BITS-1:0]   line;
        logic [COLUMN_BITS-1:0] col;
        logic [LINE_BITS-1:0]   sline;
        logic [COLUMN_BITS-1:0] scol;
        logic [LEN_W-1:0]       len;
        logic [DEPTH_BITS-1:0]  depth;
        nl_t                    nl;
        logic                   adv;
    } scan_t;

    typedef struct packed {
        scan_t                  s;
        logic                   emit;
        logic [KIND_W-1:0]      kind;
        logic [LINE_BITS-1:0]   line;
        logic [COLUMN_BITS-1:0] col;
        logic [LEN_W-1:0]       len;
        logic [ERR_W-1:0]       err;
        logic                   again;
        logic                   pwe;
        logic [IDXW-1:0]        pidx;
        logic [7:0]             pdata;
    } step_t;

    function automatic scan_t fresh();
        scan_t s;
        s = '0;
        s.mode  = M_IDLE;
        s.line  = LINE_BITS'(1);
        s.sline = LINE_BITS'(1);
        s.nl    = NL_NONE;
        return s;
    endfunction

    function automatic scan_t newline(input scan_t si, input logic [7:0] b);
        scan_t s;
        s = si;
        if (s.line < LINE_MAX) s.line = s.line + 1'b1;
        s.col = '0;
        s.nl  = (b == "\n") ? NL_LF : NL_CR;
        s.adv = 1'b0;
        return s;
    endfunction

    function automatic logic [LEN_W-1:0] len_inc(input logic [LEN_W-1:0] l);
        return (l < LEN_MAX) ? l + 1'b1 : l;
    endfunction

    function automatic step_t put(input step_t oi, input logic [KIND_W-1:0] k,
                                  input logic [LINE_BITS-1:0] ln,
                                  input logic [COLUMN_BITS-1:0] c,
                                  input logic [LEN_W-1:0] l, input logic [ERR_W-1:0] e);
        step_t o;
        o = oi;
        o.emit = 1'b1;
        o.kind = k;
        o.line = ln;
        o.col  = c;
        o.len  = l;
        o.err  = e;
        return o;
    endfunction

    function automatic step_t dispatch(input scan_t si, input logic [7:0] b,
                                       input logic [7:0][7:0] kwp);
        step_t o;
        logic [KIND_W-1:0] k;
        logic nlb;
        o = '0;
        o.s = si;
        nlb = (b == "\n") || (b == "\r");
        k = pair_kind(si.pend, b);
        case (si.mode)
            M_OP: begin
                o.s.mode = M_IDLE;
                if (si.pend == "*" && b == "/") begin
                    o = put(o, TK_EOF, si.sline, si.scol, LEN_W'(2), ERR_STRAY_CLOSE);
                    o.s.mode = M_DRAIN;
                end else if (si.pend == "/" && b == "/") begin
                    o.s.mode = M_LINE_C;
                end else if (si.pend == "/" && b == "*") begin
                    o.s.mode  = M_BLOCK;
                    o.s.depth = DEPTH_BITS'(1);
                end else if (k != TK_EOF) begin
                    o = put(o, k, si.sline, si.scol, LEN_W'(2), ERR_NONE);
                end else begin
                    o = put(o, single_kind(si.pend), si.sline, si.scol, LEN_W'(1), ERR_NONE);
                    o.again = 1'b1;
                end
            end
            M_IDENT: begin
                if (is_alpha(b) || is_digit(b)) begin
                    if (si.len < LEN_W'(KEYWORD_MAX_BYTES)) begin
                        o.pwe   = 1'b1;
                        o.pidx  = si.len[IDXW-1:0];
                        o.pdata = b;
                    end
                    o.s.len = len_inc(si.len);
                end else begin
                    // Keywords are at most eight bytes long.
                    o = put(o, (si.len <= LEN_W'(8)) ? kw_kind(kwp, si.len[3:0]) : TK_IDENT,
                            si.sline, si.scol, si.len, ERR_NONE);
                    o.s.mode = M_IDLE;
                    o.again = 1'b1;
                end
            end
            M_INT: begin
                if (is_digit(b)) begin
                    o.s.len = len_inc(si.len);
                end else if (b == ".") begin
                    o.s.len  = len_inc(si.len);
                    o.s.mode = M_FLT;
                end else begin
                    o = put(o, TK_INT, si.sline, si.scol, si.len, ERR_NONE);
                    o.s.mode = M_IDLE;
                    o.again = 1'b1;
                end
            end
            M_FLT: begin
                if (is_digit(b)) begin
                    o.s.len = len_inc(si.len);
                end else begin
                    o = put(o, TK_FLOAT, si.sline, si.scol, si.len, ERR_NONE);
                    o.s.mode = M_IDLE;
                    o.again = 1'b1;
                end
            end
            M_STR: begin
                if (b == 8'd0) begin
                    o = put(o, TK_EOF, si.line, si.col, LEN_W'(1), ERR_EOF_STRING);
                    o.s = fresh();
                end else begin
                    o.s.len = len_inc(si.len);
                    if (nlb) o.s = newline(o.s, b);
                    else if (b == "\\") o.s.mode = M_STR_ESC;
                    else if (b == "\"") begin
                        o = put(o, TK_STRING, si.sline, si.scol, o.s.len, ERR_NONE);
                        o.s.mode = M_IDLE;
                    end
                end
            end
            M_STR_ESC: begin
                o.s.mode = M_STR;
                if (b == "\"" || b == "\\") o.s.len = len_inc(si.len);
                else o.again = 1'b1;
            end
            M_LINE_C: begin
                if (b == 8'd0 || nlb) begin
                    o.s.mode = M_IDLE;
                    o.again = 1'b1;
                end
            end
            M_BLOCK: begin
                if (b == 8'd0) begin
                    o = put(o, TK_EOF, si.line, si.col, LEN_W'(1), ERR_EOF_COMMENT);
                    o.s = fresh();
                end else if (b == "/") o.s.mode = M_BLOCK_SLASH;
                else if (b == "*") o.s.mode = M_BLOCK_STAR;
                else if (nlb) o.s = newline(si, b);
            end
            M_BLOCK_SLASH: begin
                o.s.mode = M_BLOCK;
                if (b == "*") begin
                    if (si.depth < DEPTH_MAX) o.s.depth = si.depth + 1'b1;
                end else o.again = 1'b1;
            end
            M_BLOCK_STAR: begin
                o.s.mode = M_BLOCK;
                if (b == "/") begin
                    if (si.depth != '0) o.s.depth = si.depth - 1'b1;
                    if (o.s.depth == '0) o.s.mode = M_IDLE;
                end else o.again = 1'b1;
            end
            M_IDLE: begin
                if (nlb) o.s = newline(si, b);
                else if (b == " " || b == "\t") o.s = si;
                else if (b == 8'd0) begin
                    o = put(o, TK_EOF, si.line, si.col, LEN_W'(1), ERR_NONE);
                    o.s = fresh();
                end else if (b == "/" || b == "*" || b == "+" || b == "-" || b == "%" ||
                             b == "&" || b == "|" || b == "<" || b == ">" || b == "!" ||
                             b == "=") begin
                    o.s.sline = si.line;
                    o.s.scol  = si.col;
                    o.s.len   = LEN_W'(1);
                    o.s.mode  = M_OP;
                    o.s.pend  = b;
                end else if (single_kind(b) != TK_EOF) begin
                    o = put(o, single_kind(b), si.line, si.col, LEN_W'(1), ERR_NONE);
                end else if (is_alpha(b) || is_digit(b) || b == "\"") begin
                    o.s.sline = si.line;
                    o.s.scol  = si.col;
                    o.s.len   = LEN_W'(1);
                    if (is_alpha(b)) begin
                        o.s.mode = M_IDENT;
                        o.pwe    = 1'b1;
                        o.pidx   = '0;
                        o.pdata  = b;
                    end else if (is_digit(b)) o.s.mode = M_INT;
                    else o.s.mode = M_STR;
                end else begin
                    o = put(o, TK_EOF, si.line, si.col, LEN_W'(1), ERR_UNKNOWN);
                    o.s.mode = M_DRAIN;
                end
            end
            default: o.s.mode = M_DRAIN;
        endcase
        return o;
    endfunction

    scan_t scan_reg, scan_next;
    logic [7:0] prefix_reg [KEYWORD_MAX_BYTES];
    logic [7:0][7:0] kwp;
    step_t d1, d2;
    scan_t s0, sf;
    logic skip, partner, pwe;
    logic [IDXW-1:0] pidx;
    logic [7:0] pdata;
    res_t ra, rb;

    always_comb
    begin
        for (int i = 0; i < 8; i++) kwp[i] = prefix_reg[i];
    end

    always_comb
    begin
        s0 = scan_reg;
        s0.adv = 1'b1;
        skip = 1'b0;
        partner = ((source_byte == "\n") && scan_reg.nl == NL_CR) ||
                  ((source_byte == "\r") && scan_reg.nl == NL_LF);
        if (scan_reg.mode == M_DRAIN) begin
            skip = 1'b1;
            if (source_byte == 8'd0) s0 = fresh();
        end else if (scan_reg.nl != NL_NONE) begin
            s0.nl = NL_NONE;
            // The second half of a CR/LF pair is swallowed.
            if (partner) begin
                skip = 1'b1;
                if (scan_reg.mode == M_STR) s0.len = len_inc(scan_reg.len);
            end
        end
        d1 = dispatch(s0, source_byte, kwp);
        d2 = dispatch(d1.s, source_byte, kwp);
        if (skip) sf = s0;
        else if (d1.again) sf = d2.s;
        else sf = d1.s;
        if (!skip && sf.adv && sf.col < COL_MAX) sf.col = sf.col + 1'b1;
        scan_next = sf;

        pwe   = !skip && (d1.pwe || (d1.again && d2.pwe));
        pidx  = (d1.again && d2.pwe) ? d2.pidx : d1.pidx;
        pdata = (d1.again && d2.pwe) ? d2.pdata : d1.pdata;

        ra = '{d1.kind, LINE_W'(d1.line), COL_W'(d1.col), d1.len, d1.err, 1'b0};
        rb = '{d2.kind, LINE_W'(d2.line), COL_W'(d2.col), d2.len, d2.err, 1'b1};
        push = '0;
        if (accept && !skip) begin
            if (d1.emit && d1.again && d2.emit) begin
                push.count = 2'd2;
                push.r0 = ra;
                push.r1 = rb;
            end else if (d1.emit) begin
                push.count = 2'd1;
                push.r0 = ra;
                push.r0.last = 1'b1;
            end else if (d1.again && d2.emit) begin
                push.count = 2'd1;
                push.r0 = rb;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) scan_reg <= fresh();
        else if (accept) scan_reg <= scan_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept && pwe) prefix_reg[pidx] <= pdata;
    end

endmodule

`default_nettype wire

[hdl/sct_queue.sv]
// ----------------------------------------------------------------------------
// sct_queue
// Result queue: takes up to two results per cycle and hands out one per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module sct_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire sct_pkg::push_t push,
    output logic                room,
    output logic                out_valid,
    input  wire logic           out_stall,
    output sct_pkg::res_t       head
);
    import sct_pkg::*;
    `include "source_code_tokenizer_assert.svh"

    localparam int FIFO_DEPTH = 4;

    res_t entry_reg [FIFO_DEPTH];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] count_reg;
    logic pop;

    // Always keep space for the two results a single byte can cause.
    assign room      = count_reg <= 3'(FIFO_DEPTH - 2);
    assign out_valid = count_reg != 3'd0;
    assign head      = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + push.count;
            rd_ptr_reg <= rd_ptr_reg + 2'(pop);
            count_reg  <= count_reg + 3'(push.count) - 3'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0) entry_reg[wr_ptr_reg] <= push.r0;
        if (push.count == 2'd2) entry_reg[wr_ptr_reg + 2'd1] <= push.r1;
    end

    `SCT_ASSERT_IMPLIES(a_count_bound, 1'b1, count_reg <= 3'(FIFO_DEPTH), "queue overfilled")
    `SCT_ASSERT_IMPLIES(a_push_room, push.count != 2'd0, room, "push without room")
    `SCT_ASSERT_NEXT(a_pair_count, push.count == 2'd2 && !pop,
                     count_reg == $past(count_reg) + 3'd2, "pair push miscounted")

endmodule

`default_nettype wire

[hdl/source_code_tokenizer.sv]
// ----------------------------------------------------------------------------
// source_code_tokenizer
// Streaming tokenizer: one source byte in per transfer, tokens out.
// ----------------------------------------------------------------------------
// The block takes one source byte per clock while the queue has room for two
// results and emits tokens with their start line, column and length; a byte
// that ends a lookahead token can produce two results, which a four-entry
// result queue absorbs while the output side drains one result per clock
// unless out_stall holds it. The scanner state is updated once per accepted
// byte, and each result is registered in the queue before it is output.
`default_nettype none

module source_code_tokenizer #(
    parameter int KEYWORD_MAX_BYTES = 8,
    parameter int LINE_BITS         = 32,
    parameter int COLUMN_BITS       = 16,
    parameter int DEPTH_BITS        = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  source_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [5:0]       token_kind,
    output logic [31:0]      start_line,
    output logic [15:0]      start_column,
    output logic [15:0]      token_length,
    output logic [2:0]       error_code,
    output logic             last_of_run
);
    import sct_pkg::*;

    push_t push;
    res_t  head;
    logic  room;

    assign in_stall = !room;

    sct_front #(
        .KEYWORD_MAX_BYTES(KEYWORD_MAX_BYTES),
        .LINE_BITS(LINE_BITS),
        .COLUMN_BITS(COLUMN_BITS),
        .DEPTH_BITS(DEPTH_BITS)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .accept(in_valid && room),
        .source_byte(source_byte),
        .push(push)
    );

    sct_queue u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .room(room),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .head(head)
    );

    assign token_kind   = head.kind;
    assign start_line   = head.line;
    assign start_column = head.column;
    assign token_length = head.length;
    assign error_code   = head.err;
    assign last_of_run  = head.last;

endmodule

`default_nettype wire
